FILE: src/pftd_pkg.sv
package pftd_pkg;

	// Default width of the value that is factorized
	localparam int PFTD_VALUE_BITS = 32;

	// Longest run of results for one transaction
	localparam int PFTD_MAX_RESULTS = 9;

	// Fixed widths of the result fields
	localparam int PRIME_W = 32;
	localparam int EXP_W   = 6;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FLUSH
	} state_t;

	// Control from the sequencer to the result stage
	typedef struct packed {
		logic clear;  // new transaction: drop any held result
		logic push;   // a new (prime, exponent) pair is found
		logic flush;  // send the held result as the final one
	} emit_ctl_t;

endpackage

FILE: src/pftd_div.sv
module pftd_div #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient,
	output logic [W-1:0] remainder
);

	localparam int SW = (W > 1) ? $clog2(W) : 1;

	logic          run_q;
	logic          done_q;
	logic [SW-1:0] step_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  den_q;

	logic [W:0]    shifted;
	logic          fits;
	logic [W:0]    diff;

	// Shift in the next dividend bit and try the subtraction
	always_comb begin
		shifted = {rem_q, quo_q[W-1]};
		fits    = (shifted >= {1'b0, den_q});
		diff    = shifted - {1'b0, den_q};
	end

	// Step control: one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + SW'(1);
				if (step_q == SW'(W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Restoring division datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (run_q) begin
			rem_q <= fits ? diff[W-1:0] : shifted[W-1:0];
			quo_q <= {quo_q[W-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

FILE: src/pftd_out.sv
module pftd_out (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pftd_pkg::emit_ctl_t               ctl,
	input  logic [pftd_pkg::PRIME_W-1:0]      new_prime,
	input  logic [pftd_pkg::EXP_W-1:0]        new_exp,
	output logic                              valid,
	output logic [pftd_pkg::PRIME_W-1:0]      prime,
	output logic [pftd_pkg::EXP_W-1:0]        exponent,
	output logic                              last
);

	import pftd_pkg::*;

	logic               pend_v_q;
	logic [PRIME_W-1:0] pend_prime_q;
	logic [EXP_W-1:0]   pend_exp_q;
	logic               valid_q;
	logic [PRIME_W-1:0] prime_q;
	logic [EXP_W-1:0]   exp_q;
	logic               last_q;

	// Hold one result back until it is known whether another follows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			valid_q <= (ctl.push && pend_v_q && !ctl.clear) || ctl.flush;
			if (ctl.push) begin
				pend_v_q <= 1'b1;
			end else if (ctl.flush || ctl.clear) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	// Advance held result to the output register
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			pend_prime_q <= new_prime;
			pend_exp_q   <= new_exp;
		end
		if (ctl.flush) begin
			prime_q <= pend_prime_q;
			exp_q   <= pend_exp_q;
			last_q  <= 1'b1;
		end else if (ctl.push) begin
			prime_q <= pend_prime_q;
			exp_q   <= pend_exp_q;
			last_q  <= 1'b0;
		end
	end

	assign valid    = valid_q;
	assign prime    = prime_q;
	assign exponent = exp_q;
	assign last     = last_q;

endmodule

FILE: src/prime_factorizer_trial_division_core.sv
// Every division runs on the shared bit-serial divider; every trial divisor and every
// repeat division is one division. A 32-bit prime takes about 65536 trials. Zero or
// one gives its empty result (prime and exponent zero) through the flush state.
// Throughput: one transaction at a time; busy stays high until the final result is
// handed to the output register, and the next start is taken the cycle after. Each
// result is held for one cycle under valid and cannot be stalled. Asynchronous
// active-low reset returns the block to idle with no result pending.
module prime_factorizer_trial_division_core #(
	parameter int VALUE_BITS = pftd_pkg::PFTD_VALUE_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [31:0]                  value,
	output logic                         valid,
	output logic [pftd_pkg::PRIME_W-1:0] prime,
	output logic [pftd_pkg::EXP_W-1:0]   exponent,
	output logic                         last
);

	import pftd_pkg::*;

	localparam int CW = $clog2(VALUE_BITS + 1);
	localparam int NW = $clog2(PFTD_MAX_RESULTS + 1);

	state_t                state_q;
	state_t                state_d;
	logic [VALUE_BITS-1:0] rest_q;
	logic [VALUE_BITS-1:0] rest_d;
	logic [VALUE_BITS-1:0] d_q;
	logic [VALUE_BITS-1:0] d_d;
	logic [CW-1:0]         cnt_q;
	logic [CW-1:0]         cnt_d;
	logic [NW-1:0]         res_n_q;
	logic [NW-1:0]         res_n_d;

	logic [VALUE_BITS-1:0] value_m;
	logic                  accept;
	logic                  div_start;
	logic                  div_done;
	logic [VALUE_BITS-1:0] div_quo;
	logic [VALUE_BITS-1:0] div_rem;
	logic                  loop_end;
	logic                  hit;
	logic                  trial;
	logic                  cap;
	emit_ctl_t             ctl;
	logic [PRIME_W-1:0]    new_prime;
	logic [EXP_W-1:0]      new_exp;

	assign value_m  = VALUE_BITS'(value);
	assign accept   = start && !busy;
	assign busy     = (state_q != ST_IDLE);
	assign loop_end = (d_q > div_quo);
	assign hit      = (div_rem == '0);
	assign trial    = (cnt_q == '0);
	assign cap      = (res_n_q == NW'(PFTD_MAX_RESULTS - 1));

	// Shared divider: rest / d for every trial and every division step
	pftd_div #(
		.W(VALUE_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (rest_d),
		.divisor   (d_d),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Result staging and output register
	pftd_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.new_prime (new_prime),
		.new_exp   (new_exp),
		.valid     (valid),
		.prime     (prime),
		.exponent  (exponent),
		.last      (last)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (value_m <= VALUE_BITS'(1)) ? ST_FLUSH : ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					if (trial && loop_end) begin
						state_d = ST_FLUSH;
					end else if (!trial && !hit && cap) begin
						state_d = ST_FLUSH;
					end
				end
			end
			ST_FLUSH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs and datapath updates
	always_comb begin
		rest_d    = rest_q;
		d_d       = d_q;
		cnt_d     = cnt_q;
		res_n_d   = res_n_q;
		div_start = 1'b0;
		ctl       = '0;
		new_prime = PRIME_W'(d_q);
		new_exp   = EXP_W'(cnt_q);
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ctl.clear = 1'b1;
					rest_d    = value_m;
					d_d       = VALUE_BITS'(2);
					cnt_d     = '0;
					res_n_d   = '0;
					if (value_m <= VALUE_BITS'(1)) begin
						// zero or one: empty factorization
						ctl.push  = 1'b1;
						new_prime = '0;
						new_exp   = '0;
					end else begin
						div_start = 1'b1;
					end
				end
			end
			ST_DIV: begin
				if (div_done) begin
					if (trial) begin
						if (loop_end) begin
							// leftover above one is a prime of its own
							if (rest_q > VALUE_BITS'(1)) begin
								ctl.push  = 1'b1;
								new_prime = PRIME_W'(rest_q);
								new_exp   = EXP_W'(1);
							end
						end else if (hit) begin
							cnt_d     = CW'(1);
							rest_d    = div_quo;
							div_start = 1'b1;
						end else begin
							d_d       = d_q + VALUE_BITS'(1);
							div_start = 1'b1;
						end
					end else if (hit) begin
						cnt_d     = cnt_q + CW'(1);
						rest_d    = div_quo;
						div_start = 1'b1;
					end else begin
						// divisor fully divided out: record it
						ctl.push  = 1'b1;
						res_n_d   = res_n_q + NW'(1);
						cnt_d     = '0;
						d_d       = d_q + VALUE_BITS'(1);
						div_start = !cap;
					end
				end
			end
			ST_FLUSH: begin
				ctl.flush = 1'b1;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			res_n_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			res_n_q <= res_n_d;
		end
	end

	// Working value and divisor
	always_ff @(posedge clk) begin
		rest_q <= rest_d;
		d_q    <= d_d;
	end

	// A result strobe always follows a cycle of work
	a_valid_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $past(state_q == ST_DIV) || $past(state_q == ST_FLUSH))
		else $error("result strobe without a transaction in progress");

	// The final result of a run comes only from the flush step
	a_last_from_flush: assert property (@(posedge clk) disable iff (!arst_n)
		valid && last |-> $past(state_q == ST_FLUSH))
		else $error("last result not produced by flush");

	// The divider reports only while the sequencer waits on it
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside of division state");

	// No new transaction is taken while busy
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !(ctl.clear && $past(state_q != ST_FLUSH)))
		else $error("transaction restarted while busy");

endmodule

FILE: tb/sv/pftd_factor_checker.sv
`timescale 1ns / 100ps

module pftd_factor_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         busy,
	input  logic [31:0]                  value,
	input  logic                         valid,
	input  logic [pftd_pkg::PRIME_W-1:0] prime,
	input  logic [pftd_pkg::EXP_W-1:0]   exponent,
	input  logic                         last,
	output int unsigned                  fail_count,
	output int unsigned                  pending,
	output int unsigned                  item_count,
	output int unsigned                  result_count,
	output int unsigned                  empty_count
);
	import pftd_pkg::*;

	// One expected (prime, exponent) pair plus the value it came from
	typedef struct packed {
		logic [31:0]        origin;
		logic [PRIME_W-1:0] prime;
		logic [EXP_W-1:0]   exponent;
		logic               last;
	} factor_t;

	factor_t expected_factors[$];

	initial begin
		fail_count   = 0;
		pending      = 0;
		item_count   = 0;
		result_count = 0;
		empty_count  = 0;
	end

	// Print one line per mismatch and count it
	task automatic report_mismatch(input string what, input logic [31:0] origin,
			input longint unsigned want, input longint unsigned got);
		$display("%0t: mismatch on %s for value %0d: expected %0d, got %0d",
			$time, what, origin, want, got);
		fail_count++;
	endtask

	// Append one expected result at the tail of the queue
	task automatic queue_expected(input factor_t f);
		expected_factors = {expected_factors, f};
	endtask

	// Factor by trial division and queue the run of results, last one marked
	task automatic predict_factors(input logic [31:0] v);
		longint unsigned rest;
		longint unsigned divisor;
		int unsigned     cnt;
		int              n;
		bit              have_held;
		factor_t         held;
		rest      = v & ((64'd1 << PFTD_VALUE_BITS) - 1);
		n         = 0;
		have_held = 1'b0;
		if (rest <= 1) begin
			held = '{origin: v, prime: '0, exponent: '0, last: 1'b1};
			queue_expected(held);
			empty_count++;
			return;
		end
		for (divisor = 2; divisor <= rest / divisor; divisor++) begin
			if (rest % divisor == 0) begin
				cnt = 0;
				while (rest % divisor == 0) begin
					cnt++;
					rest = rest / divisor;
				end
				if (n < PFTD_MAX_RESULTS) begin
					if (have_held)
						queue_expected(held);
					held      = '{origin: v, prime: divisor[PRIME_W-1:0],
						exponent: cnt[EXP_W-1:0], last: 1'b0};
					have_held = 1'b1;
					n++;
				end
			end
		end
		// Leftover above one is itself prime
		if (rest > 1 && n < PFTD_MAX_RESULTS) begin
			if (have_held)
				queue_expected(held);
			held = '{origin: v, prime: rest[PRIME_W-1:0], exponent: EXP_W'(1),
				last: 1'b0};
		end
		held.last = 1'b1;
		queue_expected(held);
	endtask

	// Predict on each accepted transaction, compare each strobed result
	always @(posedge clk) begin
		factor_t want;
		if (arst_n) begin
			if (start && !busy) begin
				predict_factors(value);
				item_count++;
			end
			if (valid) begin
				result_count++;
				if (expected_factors.size() == 0) begin
					report_mismatch("unexpected result (prime)", 32'd0, 0, prime);
				end else begin
					want = expected_factors.pop_front();
					if (prime !== want.prime)
						report_mismatch("prime", want.origin, want.prime, prime);
					if (exponent !== want.exponent)
						report_mismatch("exponent", want.origin, want.exponent, exponent);
					if (last !== want.last)
						report_mismatch("last", want.origin, want.last, last);
				end
			end
		end
		pending = expected_factors.size();
	end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import pftd_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 20_000_000;
	localparam int          RANDOM_ITEMS = 100;
	localparam int          CALM_TAIL    = 25;
	localparam int          DRAIN_CYCLES = 200;

	logic                 clk    = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start  = 1'b0;
	logic [31:0]          value  = '0;
	logic                 busy;
	logic                 valid;
	logic [PRIME_W-1:0]   prime;
	logic [EXP_W-1:0]     exponent;
	logic                 last;

	int unsigned fail_count;
	int unsigned pending;
	int unsigned item_count;
	int unsigned result_count;
	int unsigned empty_count;
	int unsigned cycle_count = 0;

	int unsigned small_primes[25] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41,
		43, 47, 53, 59, 61, 67, 71, 73, 79, 83, 89, 97};

	// Values that hit the edges: empty runs, lone primes, high powers, all ones
	logic [31:0] directed_values[18] = '{
		32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd6, 32'd12, 32'd9409,
		32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'd223092870,
		32'd3486784401, 32'd65537, 32'd1048575, 32'hAAAA_AAAA,
		32'h5555_5555, 32'd16777213
	};

	always #5 clk = ~clk;

	prime_factorizer_trial_division_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.value    (value),
		.valid    (valid),
		.prime    (prime),
		.exponent (exponent),
		.last     (last)
	);

	pftd_factor_checker u_factor_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.value        (value),
		.valid        (valid),
		.prime        (prime),
		.exponent     (exponent),
		.last         (last),
		.fail_count   (fail_count),
		.pending      (pending),
		.item_count   (item_count),
		.result_count (result_count),
		.empty_count  (empty_count)
	);

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Offer one value, optionally after a short idle burst, and hold until taken
	task automatic send_value(input logic [31:0] v, input bit allow_gap);
		int gap;
		gap = (allow_gap && $urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		value <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Product of small prime powers, sometimes times a modest cofactor
	function automatic logic [31:0] compose_value();
		longint unsigned acc;
		longint unsigned p;
		int              k;
		int              e;
		int              n;
		acc = 1;
		n   = $urandom_range(1, 6);
		for (k = 0; k < n; k++) begin
			p = small_primes[$urandom_range(0, 24)];
			e = $urandom_range(1, 5);
			repeat (e)
				if (acc * p <= 64'hFFFF_FFFF)
					acc = acc * p;
		end
		if ($urandom_range(0, 1) == 0) begin
			p = $urandom_range(2, 4095);
			if (acc * p <= 64'hFFFF_FFFF)
				acc = acc * p;
		end
		return acc[31:0];
	endfunction

	initial begin
		int          i;
		int unsigned pick;
		logic [31:0] v;

		// Hold reset, then release on an edge
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_values[i])
			send_value(directed_values[i], 1'b1);

		// Mostly well-formed composites, some plain noise and odd shapes
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			pick = $urandom_range(0, 9);
			if (pick < 8)
				v = compose_value();
			else if (pick == 8)
				v = $urandom_range(0, 1 << 20);
			else if ($urandom_range(0, 1) == 0)
				v = 32'd1 << $urandom_range(0, 31);
			else
				v = $urandom_range(0, 3);
			send_value(v, i < RANDOM_ITEMS - CALM_TAIL);
		end
		start <= 1'b0;

		// Drain, then watch for stray results
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("factorized %0d values into %0d results, %0d of them empty runs",
			item_count, result_count, empty_count);
		$display("idle bursts on start, extremes, nine-prime run and high powers included");
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
